### src/tfce_pkg.sv
// ----------------------------------------------------------------------------
// tfce_pkg
// shared codes, characters and types of the text field column extractor
// ----------------------------------------------------------------------------
package tfce_pkg;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_DELIM  = 2'd1;
    localparam logic [1:0] CFG_RCOUNT = 2'd2;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam int VAL_W   = 16;
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] value;
    } tail_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FLUSH,
        BK_TAIL
    } bk_state_t;

endpackage

### src/text_field_column_extractor.sv
// ----------------------------------------------------------------------------
// text_field_column_extractor
// cut style column selector over a byte stream, up to eight bytes per word
// ----------------------------------------------------------------------------
//  channel   direction  tdata / payload                          side band
//  s_axis    in         in_byte, range_slot, range_first,        tuser = op
//                       range_last
//  m_axis    out        out_bytes, byte_count                    tlast = last_of_run
//  cfg       in         cfg_index, cfg_data                      -
//
//  one input word per cycle while the queue has room and no first-field dump is outstanding
//  a word that dumps N stored bytes holds s_axis_tready low until the last of its N store reads is issued,
//  which waits behind earlier queued words and m_axis stalls: one store read per cycle while m_axis is not stalled
//  output words come from a register; up to four queued commands ride out m_axis stalls
//  reset clears control state only; no clearing pass, tables are written by op 2
//  a four entry command queue lets front and back stall on their own
// ----------------------------------------------------------------------------
module text_field_column_extractor #(
    parameter int LINE_MAX    = 511,
    parameter int RANGE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // in_byte, range_slot, range_first, range_last
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_bytes, byte_count
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    import tfce_pkg::*;

    localparam int LW  = $clog2(LINE_MAX + 1);
    localparam int MAW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int QW  = LW + $bits(tail_t);

    logic            push_valid, q_full;
    logic [LW-1:0]   push_len;
    tail_t           push_tail;
    logic            q_valid, q_pop;
    logic [QW-1:0]   q_data;
    logic [LW-1:0]   q_len;
    tail_t           q_tail;
    logic            mem_we, ram_re;
    logic [MAW-1:0]  mem_waddr, ram_raddr;
    logic [7:0]      mem_wdata, ram_rdata;
    logic            flush_done;
    logic [63:0]     out_bytes;
    logic [3:0]      byte_count;

    assign cfg_ready = 1'b1;
    assign {q_len, q_tail} = q_data;
    assign m_axis_tdata = {4'b0000, byte_count, out_bytes};

    tfce_front #(
        .LINE_MAX    (LINE_MAX),
        .RANGE_SLOTS (RANGE_SLOTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .op          (s_axis_tuser),
        .in_byte     (s_axis_tdata[7:0]),
        .range_slot  (s_axis_tdata[11:8]),
        .range_first (s_axis_tdata[27:12]),
        .range_last  (s_axis_tdata[43:28]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_len    (push_len),
        .push_tail   (push_tail),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .flush_done  (flush_done)
    );

    tfce_queue #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  ({push_len, push_tail}),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    tfce_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tfce_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_len       (q_len),
        .q_tail      (q_tail),
        .q_pop       (q_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .flush_done  (flush_done),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_bytes   (out_bytes),
        .byte_count  (byte_count),
        .last_of_run (m_axis_tlast)
    );

endmodule

### src/tfce_ram.sv
// ----------------------------------------------------------------------------
// tfce_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tfce_queue.sv
// ----------------------------------------------------------------------------
// tfce_queue
// short command fifo between the front end and the back end
// ----------------------------------------------------------------------------
module tfce_queue #(
    parameter int W     = 19,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

### src/tfce_front.sv
// ----------------------------------------------------------------------------
// tfce_front
// accepts words, keeps line and field state, tests ranges and queues commands
// ----------------------------------------------------------------------------
module tfce_front #(
    parameter int LINE_MAX    = 511,
    parameter int RANGE_SLOTS = 16,
    localparam int LW  = $clog2(LINE_MAX + 1),
    localparam int FW  = $clog2(LINE_MAX + 2),
    localparam int MAW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    localparam int SW  = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [7:0]            in_byte,
    input  logic [3:0]            range_slot,
    input  logic [15:0]           range_first,
    input  logic [15:0]           range_last,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  q_full,
    output logic                  push_valid,
    output logic [LW-1:0]         push_len,
    output tfce_pkg::tail_t       push_tail,
    output logic                  mem_we,
    output logic [MAW-1:0]        mem_waddr,
    output logic [7:0]            mem_wdata,
    input  logic                  flush_done
);

    import tfce_pkg::*;

    logic                cut_mode_reg;
    logic [7:0]          delim_reg;
    logic [4:0]          rcount_reg;
    logic [VAL_W-1:0]    starts_reg [RANGE_SLOTS];
    logic [VAL_W-1:0]    ends_reg [RANGE_SLOTS];

    logic [LW-1:0]       stored_reg, stored_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [FW-1:0]       field_reg, field_next;
    logic                dseen_reg, dseen_next;
    logic                printed_reg, printed_next;
    logic                cursel_reg, cursel_next;
    logic                pend_reg, pend_next;

    logic                accept;
    logic                slot_ok;
    logic                tbl_we;
    logic                do_finish, do_clear;
    logic [VAL_W-1:0]    idx_a;
    logic                hit_a, hit_1;

    assign in_ready  = !q_full && !pend_reg;
    assign accept    = in_valid && in_ready;
    assign slot_ok   = (8'(range_slot) < 8'(RANGE_SLOTS));
    assign mem_waddr = MAW'(stored_reg);
    assign mem_wdata = in_byte;

    // range test at the next position or field, and at field one
    always_comb
    begin
        hit_a = 1'b0;
        hit_1 = 1'b0;
        idx_a = cut_mode_reg ? VAL_W'(len_reg) + 16'd1 : VAL_W'(field_reg) + 16'd1;
        for (int i = 0; i < RANGE_SLOTS; i++)
        begin
            if (8'(i) < 8'(rcount_reg))
            begin
                if (idx_a >= starts_reg[i] && (ends_reg[i] == '0 || idx_a <= ends_reg[i]))
                begin
                    hit_a = 1'b1;
                end
                if (16'd1 >= starts_reg[i] && (ends_reg[i] == '0 || 16'd1 <= ends_reg[i]))
                begin
                    hit_1 = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic printed_v;
        stored_next  = stored_reg;
        len_next     = len_reg;
        field_next   = field_reg;
        dseen_next   = dseen_reg;
        printed_next = printed_reg;
        cursel_next  = cursel_reg;
        push_len     = '0;
        push_tail    = '{has_byte: 1'b0, value: 8'h00};
        mem_we       = 1'b0;
        tbl_we       = 1'b0;
        do_finish    = 1'b0;
        do_clear     = 1'b0;
        printed_v    = printed_reg;
        if (accept)
        begin
            unique case (op)
                OP_DATA:
                begin
                    if (in_byte == CH_CR)
                    begin
                        do_clear = 1'b0;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        do_finish = 1'b1;
                    end
                    else if (len_reg < LW'(LINE_MAX))
                    begin
                        len_next = len_reg + 1'b1;
                        if (cut_mode_reg)
                        begin
                            if (hit_a)
                            begin
                                push_tail = '{has_byte: 1'b1, value: in_byte};
                            end
                        end
                        else if (in_byte == delim_reg)
                        begin
                            if (!dseen_reg)
                            begin
                                dseen_next = 1'b1;
                                if (hit_1)
                                begin
                                    push_len  = stored_reg;
                                    printed_v = 1'b1;
                                end
                                stored_next = '0;
                            end
                            field_next  = field_reg + 1'b1;
                            cursel_next = hit_a;
                            if (hit_a)
                            begin
                                if (printed_v)
                                begin
                                    push_tail = '{has_byte: 1'b1, value: delim_reg};
                                end
                                printed_v = 1'b1;
                            end
                            printed_next = printed_v;
                        end
                        else if (!dseen_reg)
                        begin
                            mem_we      = 1'b1;
                            stored_next = stored_reg + 1'b1;
                        end
                        else if (cursel_reg)
                        begin
                            push_tail = '{has_byte: 1'b1, value: in_byte};
                        end
                    end
                end
                OP_END:
                begin
                    if (len_reg != '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        do_clear = 1'b1;
                    end
                end
                OP_LOAD:
                begin
                    tbl_we = slot_ok;
                end
                default:
                begin
                    tbl_we = 1'b0;
                end
            endcase
        end
        if (do_finish)
        begin
            push_len  = (!cut_mode_reg && !dseen_reg) ? stored_reg : '0;
            push_tail = '{has_byte: 1'b1, value: CH_LF};
        end
        if (do_finish || do_clear)
        begin
            stored_next  = '0;
            len_next     = '0;
            field_next   = FW'(1);
            dseen_next   = 1'b0;
            printed_next = 1'b0;
            cursel_next  = 1'b0;
        end
        push_valid = (push_len != '0) || push_tail.has_byte;
        if (push_valid && push_len != '0)
        begin
            pend_next = 1'b1;
        end
        else if (flush_done)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            starts_reg[SW'(range_slot)] <= range_first;
            ends_reg[SW'(range_slot)]   <= range_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_mode_reg <= 1'b0;
            delim_reg    <= CH_TAB;
            rcount_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:   cut_mode_reg <= cfg_data[0];
                CFG_DELIM:  delim_reg    <= cfg_data;
                CFG_RCOUNT: rcount_reg   <= cfg_data[4:0];
                default:    rcount_reg   <= rcount_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg  <= '0;
            len_reg     <= '0;
            field_reg   <= FW'(1);
            dseen_reg   <= 1'b0;
            printed_reg <= 1'b0;
            cursel_reg  <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            stored_reg  <= stored_next;
            len_reg     <= len_next;
            field_reg   <= field_next;
            dseen_reg   <= dseen_next;
            printed_reg <= printed_next;
            cursel_reg  <= cursel_next;
            pend_reg    <= pend_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) stored_reg <= len_reg)
        else $error("stored byte count exceeds line length");

    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> !pend_reg)
        else $error("first field store written while a dump is outstanding");

endmodule

### src/tfce_back.sv
// ----------------------------------------------------------------------------
// tfce_back
// runs queued commands, dumps the first field store and packs output words
// ----------------------------------------------------------------------------
module tfce_back #(
    parameter int LINE_MAX = 511,
    localparam int LW  = $clog2(LINE_MAX + 1),
    localparam int MAW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  logic [LW-1:0]   q_len,
    input  tfce_pkg::tail_t q_tail,
    output logic            q_pop,
    output logic            ram_re,
    output logic [MAW-1:0]  ram_raddr,
    input  logic [7:0]      ram_rdata,
    output logic            flush_done,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     out_bytes,
    output logic [3:0]      byte_count,
    output logic            last_of_run
);

    import tfce_pkg::*;

    bk_state_t     state_reg, state_next;
    logic [LW-1:0] raddr_reg, raddr_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic          pend_reg, pend_next;
    tail_t         tail_reg, tail_next;
    logic [63:0]   acc_reg, acc_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_data_reg, out_data_next;
    logic [3:0]    out_cnt_reg, out_cnt_next;
    logic          out_last_reg, out_last_next;

    logic          out_free;
    logic          src_valid, src_last;
    logic [7:0]    src_byte;
    logic          complete, take;
    logic          start, issue;
    logic [63:0]   word;

    assign out_free = !out_valid_reg || out_ready;

    // byte source and read issue
    always_comb
    begin
        src_valid = 1'b0;
        src_byte  = tail_reg.value;
        src_last  = 1'b1;
        start     = 1'b0;
        issue     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                src_valid = q_valid && (q_len == '0);
                src_byte  = q_tail.value;
                start     = q_valid && (q_len != '0);
            end
            BK_FLUSH:
            begin
                src_valid = pend_reg;
                src_byte  = ram_rdata;
                src_last  = (rem_reg == '0) && !tail_reg.has_byte;
            end
            BK_TAIL:
            begin
                src_valid = 1'b1;
            end
            default:
            begin
                src_valid = 1'b0;
            end
        endcase
        complete = src_last || (cnt_reg == 3'd7);
        take     = src_valid && (!complete || out_free);
        if (state_reg == BK_FLUSH)
        begin
            issue = (rem_reg != '0) && (!pend_reg || take);
        end
        word = acc_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (3'(k) == cnt_reg)
            begin
                word[8*k +: 8] = src_byte;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (take && rem_reg == '0)
                begin
                    state_next = tail_reg.has_byte ? BK_TAIL : BK_IDLE;
                end
            end
            BK_TAIL:
            begin
                if (take)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        raddr_next     = raddr_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        tail_next      = tail_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        q_pop          = (state_reg == BK_IDLE) && q_valid && (start || take);
        ram_re         = start || issue;
        ram_raddr      = start ? '0 : MAW'(raddr_reg);
        flush_done     = (start && q_len == LW'(1)) || (issue && rem_reg == LW'(1));
        if (start)
        begin
            raddr_next = LW'(1);
            rem_next   = q_len - 1'b1;
            pend_next  = 1'b1;
            tail_next  = q_tail;
        end
        else if (state_reg == BK_FLUSH)
        begin
            pend_next = issue || (pend_reg && !take);
            if (issue)
            begin
                raddr_next = raddr_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
            end
        end
        if (take)
        begin
            if (complete)
            begin
                acc_next       = '0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = word;
                out_cnt_next   = 4'(cnt_reg) + 4'd1;
                out_last_next  = src_last;
            end
            else
            begin
                acc_next = word;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_bytes   = out_data_reg;
    assign byte_count  = out_cnt_reg;
    assign last_of_run = out_last_reg;

    always_ff @(posedge clk)
    begin
        raddr_reg    <= raddr_next;
        rem_reg      <= rem_next;
        tail_reg     <= tail_next;
        out_data_reg <= out_data_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> (cnt_reg == '0))
        else $error("partial word left over between commands");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == BK_FLUSH))
        else $error("store read outstanding outside a dump");

    assert property (@(posedge clk) disable iff (!rst_n)
        flush_done |=> (state_reg != BK_IDLE))
        else $error("dump ended before its last byte was taken");

endmodule
